@@ rtl/sgp_pkg.sv @@
// Shared types, font tables and glyph lookup for the scaled glyph expander.
package sgp_pkg;

   // Font geometry
   localparam int GLYPH_COUNT = 37;
   localparam int SLOT_W      = $clog2(GLYPH_COUNT);

   // Character codes that select a glyph
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;
   localparam logic [7:0] CHAR_A    = 8'h41;
   localparam logic [7:0] CHAR_Z    = 8'h5A;
   localparam logic [7:0] CHAR_DASH = 8'h2D;

   // Glyph slots that are not letters
   localparam logic [SLOT_W-1:0] SLOT_DASH  = SLOT_W'(16);
   localparam logic [SLOT_W-1:0] SLOT_DIGIT = SLOT_W'(17);

   // Register indexes on the configuration port
   localparam logic [1:0] REG_FG_COLOR = 2'd0;
   localparam logic [1:0] REG_BG_COLOR = 2'd1;
   localparam logic [1:0] REG_SCALE    = 2'd2;

   // Font rows, glyph row r in bits [8r+7:8r], leftmost pixel in bit 7 of the row
   localparam logic [63:0] FONT_ROM [0:GLYPH_COUNT-1] = '{
      64'h0066667E66663C18, 64'h007C66667C66667C, 64'h003C66606060663C,
      64'h007E60607C60607E, 64'h003C66666E60663C, 64'h006666667E666666,
      64'h003C18181818183C, 64'h00666C7870786C66, 64'h007E606060606060,
      64'h006363636B7F7763, 64'h003C66666666663C, 64'h006060607C66667C,
      64'h00666C787C66667C, 64'h003C66063C60663C, 64'h001818181818187E,
      64'h00183C6666666666, 64'h000000007E000000, 64'h003C66767E6E663C,
      64'h007E181818183818, 64'h007E60301C06663C, 64'h003C66061C06663C,
      64'h000C0C7E6C3C1C0C, 64'h003C6606067C607E, 64'h003C66667C60663C,
      64'h00303030180C067E, 64'h003C66663C66663C, 64'h003C66063E66663C,
      64'h0066663C183C6666, 64'h007C66666666667C, 64'h006363676F7B7363,
      64'h003C666666666666, 64'h0063777F6B636363, 64'h001818183C666666,
      64'h006060607C60607E, 64'h003C66660606061E, 64'h00366C666666663C,
      64'h007E6030180C067E
   };

   // Glyph slot for letters A to Z
   localparam logic [SLOT_W-1:0] LETTER_SLOT [0:25] = '{
      SLOT_W'(0),  SLOT_W'(1),  SLOT_W'(2),  SLOT_W'(28), SLOT_W'(3),  SLOT_W'(33),
      SLOT_W'(4),  SLOT_W'(5),  SLOT_W'(6),  SLOT_W'(34), SLOT_W'(7),  SLOT_W'(8),
      SLOT_W'(9),  SLOT_W'(29), SLOT_W'(10), SLOT_W'(11), SLOT_W'(35), SLOT_W'(12),
      SLOT_W'(13), SLOT_W'(14), SLOT_W'(30), SLOT_W'(15), SLOT_W'(31), SLOT_W'(27),
      SLOT_W'(32), SLOT_W'(36)
   };

   // One character as handed from the front end to the drawing engine
   typedef struct packed {
      logic [63:0] glyph;
      logic [3:0]  fg_color;
      logic [3:0]  bg_color;
      logic [2:0]  scale;
      logic [7:0]  cursor_x;
      logic [7:0]  line_y;
   } cmd_type;

   // Glyph rows for a character code; unsupported codes give a blank cell
   function automatic logic [63:0] glyph_bits(input logic [7:0] code);
      logic [63:0] bits;
      bits = '0;
      if (code >= CHAR_ZERO && code <= CHAR_NINE) begin
         bits = FONT_ROM[SLOT_DIGIT + SLOT_W'(code[3:0])];
      end else if (code >= CHAR_A && code <= CHAR_Z) begin
         bits = FONT_ROM[LETTER_SLOT[5'(code - CHAR_A)]];
      end else if (code == CHAR_DASH) begin
         bits = FONT_ROM[SLOT_DASH];
      end
      return bits;
   endfunction

endpackage

@@ rtl/sgp_front.sv @@
// Front end: takes characters, tracks the cursor and builds draw commands.
module sgp_front #(
   parameter int MAX_SCALE = 4
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  logic [7:0]      req_char_code,
   input  logic            req_first,
   input  logic [7:0]      req_start_x,
   input  logic [7:0]      req_start_y,
   input  logic [3:0]      fg_color,
   input  logic [3:0]      bg_color,
   input  logic [2:0]      scale,
   input  logic            queue_full,
   output logic            push_valid,
   output sgp_pkg::cmd_type push_cmd
);
   import sgp_pkg::*;

   logic [7:0] cursor_x_ff, cursor_x_in;
   logic [7:0] line_y_ff, line_y_in;
   logic [7:0] cur_x;
   logic [7:0] cur_y;
   logic [2:0] scale_clamped;
   logic       accept;

   assign req_stall  = queue_full;
   assign accept     = req_valid && !queue_full;
   assign push_valid = accept;

   // Clamp magnification to 1..MAX_SCALE
   always_comb begin
      scale_clamped = scale;
      if (scale == 3'd0) begin
         scale_clamped = 3'd1;
      end else if (scale > 3'(MAX_SCALE)) begin
         scale_clamped = 3'(MAX_SCALE);
      end
   end

   // Start of string reloads cursor and line origin
   assign cur_x = req_first ? req_start_x : cursor_x_ff;
   assign cur_y = req_first ? req_start_y : line_y_ff;

   always_comb begin
      push_cmd.glyph    = glyph_bits(req_char_code);
      push_cmd.fg_color = fg_color;
      push_cmd.bg_color = bg_color;
      push_cmd.scale    = scale_clamped;
      push_cmd.cursor_x = cur_x;
      push_cmd.line_y   = cur_y;
   end

   // Cursor moves by one scaled cell per character, wrapping at 8 bits
   always_comb begin
      cursor_x_in = cursor_x_ff;
      line_y_in   = line_y_ff;
      if (accept) begin
         cursor_x_in = 8'(cur_x + {2'b00, scale_clamped, 3'b000});
         line_y_in   = cur_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_x_ff <= '0;
         line_y_ff   <= '0;
      end else begin
         cursor_x_ff <= cursor_x_in;
         line_y_ff   <= line_y_in;
      end
   end

endmodule

@@ rtl/sgp_cmd_queue.sv @@
// Two-entry command queue between the front end and the drawing engine.
module sgp_cmd_queue (
   input  logic            clock,
   input  logic            reset,
   input  logic            push_valid,
   input  sgp_pkg::cmd_type push_cmd,
   output logic            full,
   input  logic            pop,
   output logic            pop_valid,
   output sgp_pkg::cmd_type pop_cmd
);
   import sgp_pkg::*;

   localparam int DEPTH = 2;

   cmd_type    entry_ff [DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push;
   logic       do_pop;

   assign full      = (count_ff == 2'(DEPTH));
   assign pop_valid = (count_ff != 2'd0);
   assign pop_cmd   = entry_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop && pop_valid;

   // Pointer and fill tracking
   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

@@ rtl/sgp_back.sv @@
// Drawing engine: walks a command's scanlines and chunks, one chunk a cycle unless stalled.
module sgp_back #(
   parameter int MAX_SCALE = 4,
   parameter int ROW_BYTES = 128
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            cmd_valid,
   input  sgp_pkg::cmd_type cmd,
   output logic            cmd_pop,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output logic [14:0]     rsp_vram_address,
   output logic [63:0]     rsp_pixel_bytes,
   output logic [3:0]      rsp_byte_count,
   output logic            rsp_last_of_char
);
   import sgp_pkg::*;

   localparam int NCHUNK = (4 * MAX_SCALE + 7) / 8;
   localparam int CW     = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
   localparam int SW     = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
   localparam int EW     = 16 * NCHUNK;
   localparam logic [8:0] ROW_BYTES_W = 9'(ROW_BYTES);

   cmd_type     cmd_ff, cmd_in;
   logic        busy_ff, busy_in;
   logic [2:0]  gr_ff, gr_in;
   logic [SW-1:0] sv_ff, sv_in;
   logic [CW-1:0] chunk_ff, chunk_in;
   logic [7:0]  row_ff, row_in;

   logic        out_valid_ff, out_valid_in;
   logic [14:0] addr_ff, addr_in;
   logic [63:0] bytes_ff, bytes_in;
   logic [3:0]  count_ff, count_in;
   logic        last_ff, last_in;

   logic        advance;
   logic        fire;
   logic        chunk_last;
   logic        line_last;
   logic        char_last;
   logic        load;
   logic [7:0]  row_bits;
   logic [EW-1:0] expanded;
   logic [EW-1:0] shifted;
   logic [15:0] pix;
   logic [5:0]  remain;
   logic [16:0] addr_sum;

   assign advance = !out_valid_ff || !rsp_stall;
   assign fire    = busy_ff && advance;

   // Position within the character
   assign chunk_last = ({3'b000, chunk_ff, 1'b0} + 5'd2) >= {2'b00, cmd_ff.scale};
   assign line_last  = (3'(sv_ff) == cmd_ff.scale - 3'd1);
   assign char_last  = (gr_ff == 3'd7) && line_last && chunk_last;
   assign load       = cmd_valid && (!busy_ff || (fire && char_last));
   assign cmd_pop    = load;

   // Widen the current glyph row by the scale factor, pixel 0 leftmost
   assign row_bits = cmd_ff.glyph[{gr_ff, 3'b000} +: 8];

   always_comb begin
      expanded = '0;
      case (cmd_ff.scale)
         3'd2: begin
            for (int p = 0; p < EW; p++) begin
               if (p < 16) expanded[p] = row_bits[3'(7 - p / 2)];
            end
         end
         3'd3: begin
            for (int p = 0; p < EW; p++) begin
               if (p < 24) expanded[p] = row_bits[3'(7 - p / 3)];
            end
         end
         3'd4: begin
            for (int p = 0; p < EW; p++) begin
               if (p < 32) expanded[p] = row_bits[3'(7 - p / 4)];
            end
         end
         default: begin
            for (int p = 0; p < EW; p++) begin
               if (p < 8) expanded[p] = row_bits[3'(7 - p)];
            end
         end
      endcase
   end

   // Pick the sixteen pixels of this chunk and pack them into bytes
   assign shifted = expanded >> {chunk_ff, 4'b0000};
   assign pix     = shifted[15:0];
   assign remain  = {1'b0, cmd_ff.scale, 2'b00} - 6'({chunk_ff, 3'b000});

   always_comb begin
      count_in = (remain > 6'd8) ? 4'd8 : remain[3:0];
      bytes_in = '0;
      for (int k = 0; k < 8; k++) begin
         if (4'(k) < count_in) begin
            bytes_in[8*k+4 +: 4] = pix[2*k]     ? cmd_ff.fg_color : cmd_ff.bg_color;
            bytes_in[8*k   +: 4] = pix[2*k + 1] ? cmd_ff.fg_color : cmd_ff.bg_color;
         end
      end
   end

   // Framebuffer address of the chunk, wrapping at 15 bits
   assign addr_sum = {9'b0, row_ff} * {8'b0, ROW_BYTES_W}
                   + {10'b0, cmd_ff.cursor_x[7:1]}
                   + 17'({chunk_ff, 3'b000});
   assign addr_in  = addr_sum[14:0];
   assign last_in  = char_last;

   // Walk chunks, then scanlines, then glyph rows
   always_comb begin
      cmd_in   = cmd_ff;
      busy_in  = busy_ff;
      gr_in    = gr_ff;
      sv_in    = sv_ff;
      chunk_in = chunk_ff;
      row_in   = row_ff;
      if (load) begin
         cmd_in   = cmd;
         busy_in  = 1'b1;
         gr_in    = '0;
         sv_in    = '0;
         chunk_in = '0;
         row_in   = cmd.line_y;
      end else if (fire) begin
         if (char_last) begin
            busy_in = 1'b0;
         end
         if (chunk_last) begin
            chunk_in = '0;
            row_in   = row_ff + 8'd1;
            if (line_last) begin
               sv_in = '0;
               gr_in = gr_ff + 3'd1;
            end else begin
               sv_in = sv_ff + SW'(1);
            end
         end else begin
            chunk_in = chunk_ff + CW'(1);
         end
      end
   end

   // Output register holds its transaction while the receiver stalls
   assign out_valid_in = advance ? busy_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      gr_ff    <= gr_in;
      sv_ff    <= sv_in;
      chunk_ff <= chunk_in;
      row_ff   <= row_in;
      if (fire) begin
         addr_ff  <= addr_in;
         bytes_ff <= bytes_in;
         count_ff <= count_in;
         last_ff  <= last_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_vram_address = addr_ff;
   assign rsp_pixel_bytes  = bytes_ff;
   assign rsp_byte_count   = count_ff;
   assign rsp_last_of_char = last_ff;

endmodule

@@ rtl/scaled_glyph_to_packed_pixels.sv @@
// Top level of the scaled glyph expander with its configuration registers.
//
// Usage: each req_ transaction carries one character code; req_first starts a
// new string at req_start_x / req_start_y. Each character yields 8*scale
// scanlines of 4*scale bytes, sent as rsp_ transactions of up to 8 bytes with
// their framebuffer address; rsp_last_of_char marks the final chunk.
// Results per character: 8, 16, 48 or 64 for scale 1..4, one per cycle while
// rsp_stall is low, set by the drawing engine's chunk walker, which starts the
// next queued character in the cycle after the last chunk of the previous one.
// When idle, the engine loads an accepted character from the command queue and
// registers its first chunk with rsp_valid. Input acceptance is one per cycle
// while the two-entry command queue has room.
// Registers (fg_color, bg_color, scale), written over the APB-style port, reset
// to 15, 0 and 1. Write them while the block is idle; it does not enforce this.
// Reset empties the queue and the output register and clears cursor and line.
// While rsp_stall is high the output chunk holds, the engine pauses, the
// queue fills and then req_stall rises.
module scaled_glyph_to_packed_pixels #(
   parameter int MAX_SCALE = 4,
   parameter int ROW_BYTES = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_code,
   input  logic        req_first,
   input  logic [7:0]  req_start_x,
   input  logic [7:0]  req_start_y,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [14:0] rsp_vram_address,
   output logic [63:0] rsp_pixel_bytes,
   output logic [3:0]  rsp_byte_count,
   output logic        rsp_last_of_char,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import sgp_pkg::*;

   logic [3:0] fg_color_ff, fg_color_in;
   logic [3:0] bg_color_ff, bg_color_in;
   logic [2:0] scale_ff, scale_in;
   logic       csr_write;
   logic [1:0] reg_index;

   cmd_type    push_cmd;
   cmd_type    pop_cmd;
   logic       push_valid;
   logic       queue_full;
   logic       pop_valid;
   logic       cmd_pop;

   // Configuration registers
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign reg_index = paddr[3:2];

   always_comb begin
      fg_color_in = fg_color_ff;
      bg_color_in = bg_color_ff;
      scale_in    = scale_ff;
      if (csr_write) begin
         case (reg_index)
            REG_FG_COLOR: fg_color_in = pwdata[3:0];
            REG_BG_COLOR: bg_color_in = pwdata[3:0];
            REG_SCALE:    scale_in    = pwdata[2:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_FG_COLOR: prdata = {28'b0, fg_color_ff};
         REG_BG_COLOR: prdata = {28'b0, bg_color_ff};
         REG_SCALE:    prdata = {29'b0, scale_ff};
         default:      prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fg_color_ff <= 4'd15;
         bg_color_ff <= 4'd0;
         scale_ff    <= 3'd1;
      end else begin
         fg_color_ff <= fg_color_in;
         bg_color_ff <= bg_color_in;
         scale_ff    <= scale_in;
      end
   end

   // Front end, command queue and drawing engine
   sgp_front #(
      .MAX_SCALE(MAX_SCALE)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_char_code (req_char_code),
      .req_first     (req_first),
      .req_start_x   (req_start_x),
      .req_start_y   (req_start_y),
      .fg_color      (fg_color_ff),
      .bg_color      (bg_color_ff),
      .scale         (scale_ff),
      .queue_full    (queue_full),
      .push_valid    (push_valid),
      .push_cmd      (push_cmd)
   );

   sgp_cmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .full       (queue_full),
      .pop        (cmd_pop),
      .pop_valid  (pop_valid),
      .pop_cmd    (pop_cmd)
   );

   sgp_back #(
      .MAX_SCALE(MAX_SCALE),
      .ROW_BYTES(ROW_BYTES)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cmd_valid        (pop_valid),
      .cmd              (pop_cmd),
      .cmd_pop          (cmd_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_vram_address (rsp_vram_address),
      .rsp_pixel_bytes  (rsp_pixel_bytes),
      .rsp_byte_count   (rsp_byte_count),
      .rsp_last_of_char (rsp_last_of_char)
   );

endmodule
